// ----- sv/railcom_address_confirm_defines.svh -----
// Assertion macros used by the RTL of the address confirmation block.
`ifndef RAILCOM_ADDRESS_CONFIRM_DEFINES_SVH
`define RAILCOM_ADDRESS_CONFIRM_DEFINES_SVH

// Property checked on every rising edge of i_clk outside reset.
`define RAC_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked on every rising edge of i_clk, reset included.
`define RAC_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- sv/rac_pkg.sv -----
package rac_pkg;

    localparam int TRACKS = 16;
    localparam int TRACK_W = 4;
    localparam int ADDR_W = 14;
    localparam int SYM_W = 6;
    localparam int ID_W = 4;
    localparam int BYTE_W = 8;
    localparam int CNT_W = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_BYTE_ID = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_BYTE_ID = 2'd2;

    localparam logic [CNT_W-1:0] RESET_THRESHOLD = 4'd3;
    localparam logic [ID_W-1:0] RESET_UPPER_ID = 4'd1;
    localparam logic [ID_W-1:0] RESET_LOWER_ID = 4'd2;

    typedef struct packed {
        logic [TRACK_W-1:0] track;
        logic ch1_ok;
        logic [SYM_W-1:0] ch1_symbol_first;
        logic [SYM_W-1:0] ch1_symbol_second;
        logic ch2_ok;
        logic dcc_valid;
        logic [ADDR_W-1:0] dcc_address;
    } t_in_word;

    typedef struct packed {
        logic [ADDR_W-1:0] report_address;
        logic [TRACK_W-1:0] report_track;
        logic from_channel2;
        logic last_report;
    } t_out_word;

    // An upper byte with bit 7 clear marks a short address held in the lower byte.
    function automatic logic [ADDR_W-1:0] decode_address(
        input logic [BYTE_W-1:0] upper,
        input logic [BYTE_W-1:0] lower
    );
        logic [ADDR_W-1:0] addr;
        if (upper[BYTE_W-1] == 1'b0) begin
            addr = {{(ADDR_W-BYTE_W){1'b0}}, lower};
        end else begin
            addr = {upper[5:0], lower};
        end
        return addr;
    endfunction

endpackage

// ----- sv/railcom_address_confirm.sv -----
// Channel   | Direction | Handshake                  | Payload
// cutout    | in        | i_in_valid / o_in_ready    | i_in_word  (rac_pkg::t_in_word)
// report    | out       | o_out_valid / i_out_ready  | o_out_word (rac_pkg::t_out_word)
// config    | in        | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
// A word waits in the input register, where the per-track counts are
// read, updated and written back, and then moves to a two-entry result register.
// Reports leave one at a time. A word with at most one report lets a new word in
// every cycle while i_out_ready is high; after a word with two reports the next word
// waits while the first report drains. Reset is synchronous and clears all track state.
// A stalled output holds the input register, which then holds o_in_ready low.
`include "railcom_address_confirm_defines.svh"

module railcom_address_confirm (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  rac_pkg::t_in_word                i_in_word,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output rac_pkg::t_out_word               o_out_word,
    input  logic                             i_cfg_we,
    input  logic [rac_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rac_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import rac_pkg::*;

    logic [CNT_W-1:0] r_threshold;
    logic [ID_W-1:0] r_upper_id;
    logic [ID_W-1:0] r_lower_id;

    logic [BYTE_W-1:0] r_upper_byte [TRACKS];
    logic [BYTE_W-1:0] r_lower_byte [TRACKS];
    logic [CNT_W-1:0] r_upper_cnt [TRACKS];
    logic [CNT_W-1:0] r_lower_cnt [TRACKS];

    logic r_in_v;
    t_in_word r_in;

    logic r_r0_v;
    logic r_r1_v;
    t_out_word r_r0;
    t_out_word r_r1;

    logic pop;
    logic res_free;
    logic advance;
    logic in_range;
    logic [ID_W-1:0] id;
    logic [BYTE_W-1:0] datum;
    logic [BYTE_W-1:0] cur_upper;
    logic [BYTE_W-1:0] cur_lower;
    logic [CNT_W-1:0] cur_upper_cnt;
    logic [CNT_W-1:0] cur_lower_cnt;
    logic hit_upper;
    logic hit_lower;
    logic [BYTE_W-1:0] n_upper;
    logic [BYTE_W-1:0] n_lower;
    logic [CNT_W-1:0] n_upper_cnt;
    logic [CNT_W-1:0] n_lower_cnt;
    logic ch2_hit;
    logic ch1_hit;
    t_out_word n_r0;
    t_out_word n_r1;

    assign pop = o_out_valid && i_out_ready;
    assign res_free = !(r_r0_v || r_r1_v) || (pop && (r_r0_v != r_r1_v));
    assign advance = r_in_v && res_free;
    assign o_in_ready = !r_in_v || advance;

    assign o_out_valid = r_r0_v || r_r1_v;
    assign o_out_word = r_r0_v ? r_r0 : r_r1;

    assign in_range = {1'b0, r_in.track} < (TRACK_W+1)'(TRACKS);
    assign id = r_in.ch1_symbol_first[5:2];
    assign datum = {r_in.ch1_symbol_first[1:0], r_in.ch1_symbol_second};

    assign cur_upper = r_upper_byte[r_in.track];
    assign cur_lower = r_lower_byte[r_in.track];
    assign cur_upper_cnt = r_upper_cnt[r_in.track];
    assign cur_lower_cnt = r_lower_cnt[r_in.track];

    assign hit_upper = in_range && r_in.ch1_ok && (id == r_upper_id);
    assign hit_lower = in_range && r_in.ch1_ok && (id == r_lower_id);

    // A repeated byte counts up to the threshold; a new byte restarts the count at one.
    always_comb begin
        n_upper = cur_upper;
        n_upper_cnt = cur_upper_cnt;
        if (hit_upper) begin
            n_upper = datum;
            if (datum != cur_upper) begin
                n_upper_cnt = CNT_W'(1);
            end else if (cur_upper_cnt < r_threshold) begin
                n_upper_cnt = cur_upper_cnt + CNT_W'(1);
            end
        end
        n_lower = cur_lower;
        n_lower_cnt = cur_lower_cnt;
        if (hit_lower) begin
            n_lower = datum;
            if (datum != cur_lower) begin
                n_lower_cnt = CNT_W'(1);
            end else if (cur_lower_cnt < r_threshold) begin
                n_lower_cnt = cur_lower_cnt + CNT_W'(1);
            end
        end
    end

    assign ch2_hit = in_range && r_in.ch2_ok && r_in.dcc_valid;
    assign ch1_hit = in_range && (n_upper_cnt == r_threshold) && (n_lower_cnt == r_threshold);

    always_comb begin
        n_r0.report_address = r_in.dcc_address;
        n_r0.report_track = r_in.track;
        n_r0.from_channel2 = 1'b1;
        n_r0.last_report = !ch1_hit;
        n_r1.report_address = decode_address(n_upper, n_lower);
        n_r1.report_track = r_in.track;
        n_r1.from_channel2 = 1'b0;
        n_r1.last_report = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= RESET_THRESHOLD;
            r_upper_id <= RESET_UPPER_ID;
            r_lower_id <= RESET_LOWER_ID;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_REPEAT_THRESHOLD: r_threshold <= i_cfg_data;
                CFG_UPPER_BYTE_ID: r_upper_id <= i_cfg_data;
                CFG_LOWER_BYTE_ID: r_lower_id <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < TRACKS; t++) begin
                r_upper_byte[t] <= '0;
                r_lower_byte[t] <= '0;
                r_upper_cnt[t] <= '0;
                r_lower_cnt[t] <= '0;
            end
        end else if (advance) begin
            r_upper_byte[r_in.track] <= n_upper;
            r_lower_byte[r_in.track] <= n_lower;
            r_upper_cnt[r_in.track] <= n_upper_cnt;
            r_lower_cnt[r_in.track] <= n_lower_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (o_in_ready) begin
            r_in_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r0_v <= 1'b0;
            r_r1_v <= 1'b0;
        end else if (advance) begin
            r_r0_v <= ch2_hit;
            r_r1_v <= ch1_hit;
        end else if (pop) begin
            if (r_r0_v) begin
                r_r0_v <= 1'b0;
            end else begin
                r_r1_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_r0 <= n_r0;
            r_r1 <= n_r1;
        end
    end

    `RAC_ASSERT(a_ch2_slot_kind, r_r0_v |-> r_r0.from_channel2, "Wrong word in channel-2 slot.")
    `RAC_ASSERT(a_ch1_slot_last, r_r1_v |-> (r_r1.last_report && !r_r1.from_channel2),
                "Wrong word in channel-1 slot.")
    `RAC_ASSERT(a_last_flag, r_r0_v |-> (r_r0.last_report != r_r1_v),
                "Last flag disagrees with the pending channel-1 word.")
    `RAC_ASSERT(a_blocked_holds, (r_in_v && !res_free) |=> r_in_v, "Blocked input word was lost.")
    `RAC_ASSERT_ALWAYS(a_reset_clears, !$past(i_rst_n) |-> (!r_in_v && !o_out_valid),
                       "Reset left a word pending.")

endmodule
